>>> rtl/core/bmhq_pkg.sv
// Package for the binary min-heap queue: sizes, codes, state and control types.
package bmhq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = ADDR_W + 2;
    localparam int COUNT_W   = 11;

    typedef logic signed [KEY_WIDTH-1:0] key_t;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_POP_RD,
        S_DN_CHK,
        S_DN_CMP,
        S_FINISH
    } state_t;

    typedef struct packed
    {
        logic start;
        logic write_item;
        logic up_issue;
        logic up_cmp;
        logic pop_load;
        logic dn_issue;
        logic dn_cmp;
        logic load_out;
    } cmd_t;

    typedef struct packed
    {
        logic start_ins;
        logic full;
        logic empty;
        logic pos_zero;
        logic has_left;
        logic count_zero;
        logic up_move;
        logic dn_move;
    } stat_t;

endpackage

>>> rtl/core/bmhq_in_if.sv
// Request channel interface: operation and key word.
interface bmhq_in_if;

    logic                 valid;
    logic                 ready;
    bmhq_pkg::op_t        op;
    bmhq_pkg::key_t       key_in;

    modport source (output valid, output op, output key_in, input ready);
    modport sink   (input valid, input op, input key_in, output ready);

endinterface

>>> rtl/core/bmhq_out_if.sv
// Response channel interface: popped key, status and count word.
interface bmhq_out_if;

    logic                         valid;
    logic                         ready;
    bmhq_pkg::key_t               key_out;
    bmhq_pkg::status_t            status;
    logic [bmhq_pkg::COUNT_W-1:0] count;

    modport source (output valid, output key_out, output status, output count, input ready);
    modport sink   (input valid, input key_out, input status, input count, output ready);

endinterface

>>> rtl/core/bmhq_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> rtl/core/bmhq_ctrl.sv
// Controller state machine sequencing inserts, pops and the sift loops.
module bmhq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    input  bmhq_pkg::stat_t stat,
    output bmhq_pkg::cmd_t  cmd
);

    bmhq_pkg::state_t state_reg;
    bmhq_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (stat.start_ins)
                    begin
                        state_next = stat.full ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP_CHK;
                    end
                    else
                    begin
                        state_next = stat.empty ? bmhq_pkg::S_FINISH : bmhq_pkg::S_POP_RD;
                    end
                end
            end
            bmhq_pkg::S_UP_CHK:
            begin
                state_next = stat.pos_zero ? bmhq_pkg::S_FINISH : bmhq_pkg::S_UP_CMP;
            end
            bmhq_pkg::S_UP_CMP:
            begin
                state_next = stat.up_move ? bmhq_pkg::S_UP_CHK : bmhq_pkg::S_FINISH;
            end
            bmhq_pkg::S_POP_RD:
            begin
                state_next = stat.count_zero ? bmhq_pkg::S_FINISH : bmhq_pkg::S_DN_CHK;
            end
            bmhq_pkg::S_DN_CHK:
            begin
                state_next = stat.has_left ? bmhq_pkg::S_DN_CMP : bmhq_pkg::S_FINISH;
            end
            bmhq_pkg::S_DN_CMP:
            begin
                state_next = stat.dn_move ? bmhq_pkg::S_DN_CHK : bmhq_pkg::S_FINISH;
            end
            bmhq_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = bmhq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bmhq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            bmhq_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = req_valid;
            end
            bmhq_pkg::S_UP_CHK:
            begin
                cmd.write_item = stat.pos_zero;
                cmd.up_issue   = !stat.pos_zero;
            end
            bmhq_pkg::S_UP_CMP:
            begin
                cmd.up_cmp = 1'b1;
            end
            bmhq_pkg::S_POP_RD:
            begin
                cmd.pop_load = 1'b1;
            end
            bmhq_pkg::S_DN_CHK:
            begin
                cmd.write_item = !stat.has_left;
                cmd.dn_issue   = stat.has_left;
            end
            bmhq_pkg::S_DN_CMP:
            begin
                cmd.dn_cmp = 1'b1;
            end
            bmhq_pkg::S_FINISH:
            begin
                cmd.load_out = slot_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bmhq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/bmhq_datapath.sv
// Datapath: heap memory, count, sift registers, comparators and result word.
module bmhq_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bmhq_pkg::cmd_t               cmd,
    output bmhq_pkg::stat_t              stat,
    input  bmhq_pkg::op_t                in_op,
    input  bmhq_pkg::key_t               in_key,
    output bmhq_pkg::key_t               out_key,
    output bmhq_pkg::status_t            out_status,
    output logic [bmhq_pkg::COUNT_W-1:0] out_count
);

    logic [bmhq_pkg::CNT_W-1:0]   count_reg;
    logic [bmhq_pkg::CNT_W-1:0]   count_next;
    bmhq_pkg::key_t               item_reg;
    bmhq_pkg::key_t               item_next;
    logic [bmhq_pkg::ADDR_W-1:0]  pos_reg;
    logic [bmhq_pkg::ADDR_W-1:0]  pos_next;
    logic [bmhq_pkg::ADDR_W-1:0]  parent_reg;
    logic [bmhq_pkg::ADDR_W-1:0]  parent_next;
    logic [bmhq_pkg::ADDR_W-1:0]  left_reg;
    logic [bmhq_pkg::ADDR_W-1:0]  left_next;
    logic                         has_right_reg;
    logic                         has_right_next;
    bmhq_pkg::key_t               key_reg;
    bmhq_pkg::key_t               key_next;
    bmhq_pkg::status_t            status_reg;
    bmhq_pkg::status_t            status_next;
    bmhq_pkg::key_t               out_key_reg;
    bmhq_pkg::status_t            out_status_reg;
    logic [bmhq_pkg::COUNT_W-1:0] out_count_reg;

    logic [bmhq_pkg::IDX_W-1:0]   left_idx;
    logic [bmhq_pkg::IDX_W-1:0]   right_idx;
    logic [bmhq_pkg::IDX_W-1:0]   count_ext;
    logic [bmhq_pkg::ADDR_W-1:0]  parent_idx;
    logic                         full;
    logic                         empty;
    logic                         has_left;
    logic                         has_right;
    logic                         up_move;
    logic                         pick_right;
    logic                         dn_move;
    bmhq_pkg::key_t               child_val;
    logic [bmhq_pkg::ADDR_W-1:0]  child_idx;

    logic                                 we;
    logic [bmhq_pkg::ADDR_W-1:0]          waddr;
    logic [bmhq_pkg::KEY_WIDTH-1:0]       wdata;
    logic [bmhq_pkg::ADDR_W-1:0]          raddr0;
    logic [bmhq_pkg::ADDR_W-1:0]          raddr1;
    logic [bmhq_pkg::KEY_WIDTH-1:0]       rdata0;
    logic [bmhq_pkg::KEY_WIDTH-1:0]       rdata1;
    bmhq_pkg::key_t                       rd0;
    bmhq_pkg::key_t                       rd1;

    assign rd0 = bmhq_pkg::key_t'(rdata0);
    assign rd1 = bmhq_pkg::key_t'(rdata1);

    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + bmhq_pkg::IDX_W'(1);
    assign count_ext  = bmhq_pkg::IDX_W'(count_reg);
    assign parent_idx = (pos_reg - bmhq_pkg::ADDR_W'(1)) >> 1;
    assign full       = count_reg == bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY);
    assign empty      = count_reg == '0;
    assign has_left   = left_idx < count_ext;
    assign has_right  = right_idx < count_ext;
    assign up_move    = rd0 > item_reg;
    assign pick_right = has_right_reg && (rd1 < rd0);
    assign child_val  = pick_right ? rd1 : rd0;
    assign child_idx  = pick_right ? left_reg + bmhq_pkg::ADDR_W'(1) : left_reg;
    assign dn_move    = child_val < item_reg;

    always_comb
    begin
        stat            = '0;
        stat.start_ins  = in_op == bmhq_pkg::OP_INSERT;
        stat.full       = full;
        stat.empty      = empty;
        stat.pos_zero   = pos_reg == '0;
        stat.has_left   = has_left;
        stat.count_zero = empty;
        stat.up_move    = up_move;
        stat.dn_move    = dn_move;
    end

    // read port 1 defaults to the last entry for the pop start
    always_comb
    begin
        raddr0 = '0;
        raddr1 = bmhq_pkg::ADDR_W'(count_reg - bmhq_pkg::CNT_W'(1));
        if (cmd.up_issue)
        begin
            raddr0 = parent_idx;
        end
        else if (cmd.dn_issue)
        begin
            raddr0 = left_idx[bmhq_pkg::ADDR_W-1:0];
            raddr1 = right_idx[bmhq_pkg::ADDR_W-1:0];
        end
    end

    always_comb
    begin
        we    = cmd.write_item || cmd.up_cmp || cmd.dn_cmp;
        waddr = pos_reg;
        wdata = item_reg;
        if (cmd.up_cmp && up_move)
        begin
            wdata = rd0;
        end
        else if (cmd.dn_cmp && dn_move)
        begin
            wdata = child_val;
        end
    end

    bmhq_ram #(
        .WIDTH (bmhq_pkg::KEY_WIDTH),
        .DEPTH (bmhq_pkg::CAPACITY)
    ) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    always_comb
    begin
        count_next     = count_reg;
        item_next      = item_reg;
        pos_next       = pos_reg;
        parent_next    = parent_reg;
        left_next      = left_reg;
        has_right_next = has_right_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        if (cmd.start)
        begin
            key_next = '0;
            if (in_op == bmhq_pkg::OP_INSERT)
            begin
                if (full)
                begin
                    status_next = bmhq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = bmhq_pkg::ST_OK;
                    item_next   = in_key;
                    pos_next    = count_reg[bmhq_pkg::ADDR_W-1:0];
                    count_next  = count_reg + bmhq_pkg::CNT_W'(1);
                end
            end
            else
            begin
                if (empty)
                begin
                    status_next = bmhq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next = bmhq_pkg::ST_OK;
                    count_next  = count_reg - bmhq_pkg::CNT_W'(1);
                end
            end
        end
        if (cmd.up_issue)
        begin
            parent_next = parent_idx;
        end
        if (cmd.up_cmp && up_move)
        begin
            pos_next = parent_reg;
        end
        if (cmd.pop_load)
        begin
            key_next  = rd0;
            item_next = rd1;
            pos_next  = '0;
        end
        if (cmd.dn_issue)
        begin
            left_next      = left_idx[bmhq_pkg::ADDR_W-1:0];
            has_right_next = has_right;
        end
        if (cmd.dn_cmp && dn_move)
        begin
            pos_next = child_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        pos_reg       <= pos_next;
        parent_reg    <= parent_next;
        left_reg      <= left_next;
        has_right_reg <= has_right_next;
        key_reg       <= key_next;
        status_reg    <= status_next;
        if (cmd.load_out)
        begin
            out_key_reg    <= key_reg;
            out_status_reg <= status_reg;
            out_count_reg  <= bmhq_pkg::COUNT_W'(count_reg);
        end
    end

    assign out_key    = out_key_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bmhq_pkg::CNT_W'(bmhq_pkg::CAPACITY))
        else $error("heap count above capacity");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.start |=> $stable(count_reg))
        else $error("heap count changed outside item start");

    a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop_load |-> status_reg == bmhq_pkg::ST_OK)
        else $error("root load on a failed pop");

    a_dn_child: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dn_cmp |-> left_reg < bmhq_pkg::ADDR_W'(count_reg))
        else $error("sift-down compare without a valid child");
`endif

endmodule

>>> rtl/core/binary_min_heap_queue.sv
// Binary min-heap priority queue of signed 32-bit keys, 1024 entries deep.
// Each request word is an insert or a pop and yields one response word with the popped key
// (zero unless a pop succeeds), a status and the count after the operation. A refused word
// (pop on empty, insert on full) goes from the accept step straight to the response load.
// Otherwise each compared heap level takes a read step, issuing the parent or both child
// reads to the two-read-port heap RAM, and a compare step that writes back, besides the
// accept step, the response load, a root read on a pop and a final write when the sift
// runs out of parent or children. The longest case is an insert that climbs ten levels
// to the root. A new request is taken as soon as the previous one has moved into the
// response register, even while that word waits; the next load then stalls until it is accepted.
module binary_min_heap_queue (
    input  logic         clk,
    input  logic         rst_n,
    bmhq_in_if.sink      req,
    bmhq_out_if.source   rsp
);

    bmhq_pkg::cmd_t  cmd;
    bmhq_pkg::stat_t stat;

    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bmhq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (req.op),
        .in_key     (req.key_in),
        .out_key    (rsp.key_out),
        .out_status (rsp.status),
        .out_count  (rsp.count)
    );

endmodule

>>> bench/binary_min_heap_queue_test.sv
// Self-checking testbench for the binary min-heap queue: heap predictor, scoreboard, drivers.
module binary_min_heap_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct
    {
        bmhq_pkg::key_t               key;
        bmhq_pkg::status_t            status;
        logic [bmhq_pkg::COUNT_W-1:0] count;
    } heap_response_t;

    class heap_scoreboard;
        bmhq_pkg::key_t store [bmhq_pkg::CAPACITY];
        int unsigned    held;
        int unsigned    peak;
        heap_response_t pending [$];
        int unsigned    errors;
        int unsigned    inserts_ok;
        int unsigned    pops_ok;
        int unsigned    empty_pops;
        int unsigned    full_inserts;

        // Model one accepted request word and queue the response it must produce.
        function void note_request(bmhq_pkg::op_t op, bmhq_pkg::key_t key);
            heap_response_t rsp;
            int unsigned    pos;
            int unsigned    parent;
            int unsigned    child;
            bmhq_pkg::key_t item;
            rsp.key    = '0;
            rsp.status = bmhq_pkg::ST_OK;
            if (op == bmhq_pkg::OP_INSERT)
            begin
                if (held >= bmhq_pkg::CAPACITY)
                begin
                    rsp.status = bmhq_pkg::ST_FULL;
                    full_inserts++;
                end
                else
                begin
                    pos = held;
                    held++;
                    while (pos > 0)
                    begin
                        parent = (pos - 1) / 2;
                        if (store[parent] > key)
                        begin
                            store[pos] = store[parent];
                            pos = parent;
                        end
                        else
                        begin
                            break;
                        end
                    end
                    store[pos] = key;
                    inserts_ok++;
                    if (held > peak)
                    begin
                        peak = held;
                    end
                end
            end
            else
            begin
                if (held == 0)
                begin
                    rsp.status = bmhq_pkg::ST_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    rsp.key = store[0];
                    held--;
                    pops_ok++;
                    if (held > 0)
                    begin
                        item = store[held];
                        pos = 0;
                        while (1)
                        begin
                            child = 2 * pos + 1;
                            if (child >= held)
                            begin
                                break;
                            end
                            if (child + 1 < held && store[child + 1] < store[child])
                            begin
                                child++;
                            end
                            if (store[child] < item)
                            begin
                                store[pos] = store[child];
                                pos = child;
                            end
                            else
                            begin
                                break;
                            end
                        end
                        store[pos] = item;
                    end
                end
            end
            rsp.count = held[bmhq_pkg::COUNT_W-1:0];
            pending.push_back(rsp);
        endfunction

        function void check_response(bmhq_pkg::key_t key, bmhq_pkg::status_t status,
                                     logic [bmhq_pkg::COUNT_W-1:0] count);
            heap_response_t exp_rsp;
            if (pending.size() == 0)
            begin
                $display("%0t: response word with nothing pending: key %0d status %0d count %0d",
                         $time, key, status, count);
                errors++;
                return;
            end
            exp_rsp = pending.pop_front();
            if (key !== exp_rsp.key)
            begin
                $display("%0t: key_out mismatch: expected %0d actual %0d",
                         $time, exp_rsp.key, key);
                errors++;
            end
            if (status !== exp_rsp.status)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_rsp.status, status);
                errors++;
            end
            if (count !== exp_rsp.count)
            begin
                $display("%0t: count mismatch: expected %0d actual %0d",
                         $time, exp_rsp.count, count);
                errors++;
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    int unsigned    idle_pct;
    int unsigned    stall_pct;
    heap_scoreboard sb;

    bmhq_in_if  req_ch ();
    bmhq_out_if rsp_ch ();

    binary_min_heap_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // Biased toward duplicates and extremes so equal-key tie rules get exercised.
    function automatic bmhq_pkg::key_t random_key();
        case ($urandom_range(3))
            0: return bmhq_pkg::key_t'($signed($urandom_range(16)) - 8);
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'sh7fff_ffff;
                    1: return 32'sh8000_0000;
                    2: return 32'sh0000_0000;
                    default: return 32'shffff_ffff;
                endcase
            end
            default: return bmhq_pkg::key_t'($urandom);
        endcase
    endfunction

    // Called just after a rising edge; returns just after the edge that accepted the word.
    task automatic send_word(input bmhq_pkg::op_t op, input bmhq_pkg::key_t key);
        while ($urandom_range(99) < idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.op     <= op;
        req_ch.key_in <= key;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_request(op, key);
    endtask

    task automatic random_phase(input int n, input int unsigned insert_pct,
                                input int unsigned idle, input int unsigned stall);
        int unsigned pct;
        idle_pct  = idle;
        stall_pct = stall;
        repeat (n)
        begin
            pct = (sb.held >= bmhq_pkg::CAPACITY) ? 50 : insert_pct;
            send_word(($urandom_range(99) < pct) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_POP,
                      random_key());
        end
    endtask

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            sb.check_response(rsp_ch.key_out, rsp_ch.status, rsp_ch.count);
        end
        rsp_ch.ready <= (rst_n && $urandom_range(99) >= stall_pct);
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        sb = new;
        idle_pct  = 0;
        stall_pct = 0;
        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.op     <= bmhq_pkg::OP_INSERT;
        req_ch.key_in <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, extremes, ties, bit patterns
        send_word(bmhq_pkg::OP_POP, '0);
        send_word(bmhq_pkg::OP_POP, 32'sh1234_5678);
        send_word(bmhq_pkg::OP_INSERT, 32'sh7fff_ffff);
        send_word(bmhq_pkg::OP_INSERT, 32'sh8000_0000);
        send_word(bmhq_pkg::OP_INSERT, 32'sh0000_0000);
        send_word(bmhq_pkg::OP_INSERT, 32'shffff_ffff);
        send_word(bmhq_pkg::OP_INSERT, 32'sh0000_0001);
        send_word(bmhq_pkg::OP_INSERT, 32'sh0000_0005);
        send_word(bmhq_pkg::OP_INSERT, 32'sh0000_0005);
        send_word(bmhq_pkg::OP_INSERT, 32'sh0000_0005);
        send_word(bmhq_pkg::OP_INSERT, 32'shffff_ffff);
        repeat (10) send_word(bmhq_pkg::OP_POP, '0);
        send_word(bmhq_pkg::OP_INSERT, 32'shaaaa_aaaa);
        send_word(bmhq_pkg::OP_INSERT, 32'sh5555_5555);
        send_word(bmhq_pkg::OP_POP, '0);
        send_word(bmhq_pkg::OP_POP, '0);

        random_phase(60, 50, 0, 0);
        // fill to capacity, then bounce against the full limit
        random_phase(1100, 99, 65, 0);
        random_phase(100, 30, 0, 65);
        random_phase(65, 50, 38, 38);

        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Covered %0d inserts, %0d pops, %0d pops on empty, %0d inserts on full.",
                 sb.inserts_ok, sb.pops_ok, sb.empty_pops, sb.full_inserts);
        $display("Peak occupancy %0d of %0d entries.", sb.peak, bmhq_pkg::CAPACITY);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
